>>> src/sfce_pkg.sv
// Shared types and constants for the serial frame CRC encoder.
package sfce_pkg;

  localparam logic [7:0]  StartByteRst = 8'hA5;
  localparam logic [15:0] CommandIdRst = 16'h0301;
  localparam logic [7:0]  Crc8Init     = 8'hFF;
  localparam logic [7:0]  Crc8Poly     = 8'h8C;
  localparam logic [15:0] Crc16Init    = 16'hFFFF;
  localparam logic [15:0] Crc16Poly    = 16'h8408;

  localparam int unsigned QueueDepthDef = 2;

  // configuration register indexes
  localparam logic CfgStartByte = 1'b0;
  localparam logic CfgCommandId = 1'b1;

  // one accepted input beat that belongs to a frame
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] payload_length;
    logic [7:0]  sequence_number;
  } sfce_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sfce_q_status_t;

endpackage

>>> src/sfce_front.sv
// Input side: accepts beats, drops bytes outside a frame, tracks frame state.
module sfce_front import sfce_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     payload_byte_i,
  input  logic           first_byte_i,
  input  logic           last_byte_i,
  input  logic [15:0]    payload_length_i,
  input  logic [7:0]     sequence_number_i,
  input  sfce_q_status_t q_status_i,
  output logic           push_o,
  output sfce_item_t     push_item_o
);

  logic inside_q, inside_d;
  logic accept;
  logic keep;

  always_comb begin
    in_stall_o = q_status_i.full;
    accept     = in_valid_i && !q_status_i.full;
    keep       = first_byte_i || inside_q;
    push_o     = accept && keep;
    inside_d   = inside_q;
    if (push_o) begin
      inside_d = !last_byte_i;
    end
    push_item_o.payload_byte    = payload_byte_i;
    push_item_o.first_byte      = first_byte_i;
    push_item_o.last_byte       = last_byte_i;
    push_item_o.payload_length  = payload_length_i;
    push_item_o.sequence_number = sequence_number_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else begin
      inside_q <= inside_d;
    end
  end

endmodule

>>> src/sfce_queue.sv
// Small FIFO of frame items between the input side and the byte sequencer.
module sfce_queue import sfce_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfce_item_t     push_item_i,
  input  logic           pop_i,
  output sfce_item_t     head_o,
  output sfce_q_status_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  sfce_item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  always_comb begin
    status_o.empty = (count_q == '0);
    status_o.full  = (count_q == CntFull);
    do_push = push_i && !status_o.full;
    do_pop  = pop_i && !status_o.empty;
    head_o  = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> src/sfce_back.sv
// Byte sequencer: emits header, payload and CRC-16 bytes, one per cycle while an item is queued and not stalled.
module sfce_back import sfce_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     start_byte_i,
  input  logic [15:0]    command_id_i,
  input  sfce_item_t     head_i,
  input  sfce_q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     tx_byte_o,
  output logic           frame_end_o
);

  localparam logic [3:0] PhStart  = 4'd0;
  localparam logic [3:0] PhLenLo  = 4'd1;
  localparam logic [3:0] PhLenHi  = 4'd2;
  localparam logic [3:0] PhSeq    = 4'd3;
  localparam logic [3:0] PhCrc8   = 4'd4;
  localparam logic [3:0] PhCmdLo  = 4'd5;
  localparam logic [3:0] PhCmdHi  = 4'd6;
  localparam logic [3:0] PhData   = 4'd7;
  localparam logic [3:0] PhCrcLo  = 4'd8;
  localparam logic [3:0] PhCrcHi  = 4'd9;

  function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc8Poly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

  logic        active_q, active_d;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] crc16_q, crc16_d;
  logic [7:0]  crc8_q, crc8_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;

  logic [3:0]  cur;
  logic        load_ok, emit, done;
  logic [7:0]  byte_sel;
  logic [15:0] crc16_base;

  always_comb begin
    cur     = active_q ? phase_q : (head_i.first_byte ? PhStart : PhData);
    load_ok = !out_valid_q || !out_stall_i;
    emit    = !q_status_i.empty && load_ok;

    case (cur)
      PhStart: byte_sel = start_byte_i;
      PhLenLo: byte_sel = head_i.payload_length[7:0];
      PhLenHi: byte_sel = head_i.payload_length[15:8];
      PhSeq:   byte_sel = head_i.sequence_number;
      PhCrc8:  byte_sel = crc8_q;
      PhCmdLo: byte_sel = command_id_i[7:0];
      PhCmdHi: byte_sel = command_id_i[15:8];
      PhData:  byte_sel = head_i.payload_byte;
      PhCrcLo: byte_sel = crc16_q[7:0];
      PhCrcHi: byte_sel = crc16_q[15:8];
      default: byte_sel = 8'h00;
    endcase

    done = (cur == PhCrcHi) || ((cur == PhData) && !head_i.last_byte);
    pop_o = emit && done;

    crc16_base = (cur == PhStart) ? Crc16Init : crc16_q;

    active_d = active_q;
    phase_d  = phase_q;
    crc16_d  = crc16_q;
    crc8_d   = crc8_q;
    if (emit) begin
      active_d = !done;
      phase_d  = cur + 4'd1;
      if (cur <= PhData) begin
        crc16_d = crc16_fold(crc16_base, byte_sel);
      end
      if (cur == PhStart) begin
        crc8_d = crc8_fold(Crc8Init, byte_sel);
      end else if (cur <= PhSeq) begin
        crc8_d = crc8_fold(crc8_q, byte_sel);
      end
    end

    // output register: load on emit, else drop once taken
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_sel;
      out_end_d   = (cur == PhCrcHi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      phase_q     <= PhStart;
      crc16_q     <= Crc16Init;
      crc8_q      <= Crc8Init;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      phase_q     <= phase_d;
      crc16_q     <= crc16_d;
      crc8_q      <= crc8_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = out_byte_q;
  assign frame_end_o = out_end_q;

endmodule

>>> src/serial_frame_crc_encoder_top.sv
// Top level of the serial frame encoder with header CRC-8 and frame CRC-16.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid_i/in_stall_o | payload byte, flags, length, sequence
//   out     | output    | out_valid_o/out_stall_i | tx_byte, frame_end
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index, write data
//
// One output byte per cycle while an item is queued and the output is not
// stalled; a frame-opening byte yields 7 header bytes plus the byte (plus 2 CRC
// bytes if it also closes): 8 to 10 bytes, a middle byte 1, a closing byte 3.
// Input beats queue in a QueueDepth-entry FIFO; in_stall_o is high when it is full.
// Bytes outside a frame are accepted and dropped. Reset is asynchronous, active low.
// Output bytes sit in a register that holds while out_stall_i is high.
module serial_frame_crc_encoder_top import sfce_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  sequence_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]     start_byte_q;
  logic [15:0]    command_id_q;
  logic           push, pop;
  sfce_item_t     push_item, head;
  sfce_q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      command_id_q <= CommandIdRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartByte: start_byte_q <= cfg_data_i[7:0];
        CfgCommandId: command_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfce_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .payload_byte_i    (payload_byte_i),
    .first_byte_i      (first_byte_i),
    .last_byte_i       (last_byte_i),
    .payload_length_i  (payload_length_i),
    .sequence_number_i (sequence_number_i),
    .q_status_i        (q_status),
    .push_o            (push),
    .push_item_o       (push_item)
  );

  sfce_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  sfce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_byte_q),
    .command_id_i (command_id_q),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
